/* sv/gwcb_pkg.sv */
package gwcb_pkg;

  // Map geometry. The map is addressed as {row, column} with power-of-two fields.
  localparam int MAX_COLS  = 2048;
  localparam int MAX_ROWS  = 1024;
  localparam int MAP_COL_W = $clog2(MAX_COLS);
  localparam int MAP_ROW_W = $clog2(MAX_ROWS);
  localparam int PIX_W     = MAP_COL_W + MAP_ROW_W;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ADDR_W    = PIX_W - BIT_W;
  localparam int MAP_DEPTH = 1 << ADDR_W;

  // Field and working widths.
  localparam int X_W      = 11;
  localparam int Y_W      = 10;
  localparam int PIXV_W   = 8;
  localparam int COORD_W  = 13;
  localparam int HALF_W   = 12;
  localparam int STAT_W   = 2;
  localparam int SIZE_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam int COLS_W   = 12;
  localparam int ROWS_W   = 11;
  localparam int INIT_W   = 10;
  localparam int STEP_W   = 10;
  localparam int MAXH_W   = 11;

  // Request kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_HIGH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HALF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HALF   = 3'd4;

  // Effective configuration seen by the sequencer.
  typedef struct packed {
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;
    logic [INIT_W-1:0]  init_half;
    logic [STEP_W-1:0]  step;
    logic [MAXH_W-1:0]  max_half;
  } cfg_t;

  // One access to the map memory.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } map_req_t;

  // One result of a query.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] window_size;
  } res_t;

  // Flat bit index of a pixel in the map.
  function automatic logic [PIX_W-1:0] pix_index(input logic [COORD_W-1:0] px,
                                                 input logic [COORD_W-1:0] py);
    return {py[MAP_ROW_W-1:0], px[MAP_COL_W-1:0]};
  endfunction

endpackage

/* sv/gwcb_map.sv */
module gwcb_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gwcb_pkg::map_req_t           req,
  output logic [gwcb_pkg::WORD_W-1:0]  rdata,
  output logic                         busy
);
  import gwcb_pkg::*;

  logic [WORD_W-1:0] mem [MAP_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              clearing_r;

  // Clearing pass after reset: one word per cycle through the whole map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == {ADDR_W{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Map storage with one registered read port and one write port.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clearing_r;

endmodule

/* sv/gwcb_seq.sv */
module gwcb_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gwcb_pkg::cfg_t               cfg,
  input  logic                         item_accept,
  input  logic                         item_kind,
  input  logic [gwcb_pkg::X_W-1:0]     item_x,
  input  logic [gwcb_pkg::Y_W-1:0]     item_y,
  input  logic [gwcb_pkg::PIXV_W-1:0]  item_pixel,
  output logic                         item_ready,
  output gwcb_pkg::map_req_t           map_req,
  input  logic [gwcb_pkg::WORD_W-1:0]  map_rdata,
  output logic                         res_valid,
  output gwcb_pkg::res_t               res,
  input  logic                         res_take
);
  import gwcb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRRD  = 4'd1;
  localparam logic [3:0] S_WRWB  = 4'd2;
  localparam logic [3:0] S_QCHK  = 4'd3;
  localparam logic [3:0] S_LOOP  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_GROW  = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]         state_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic               pix_nz_r;
  logic [HALF_W-1:0]  h_r;
  logic               found_r;
  logic [COORD_W-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [1:0]         seg_r;
  logic [HALF_W-1:0]  idx_r, last_r;
  logic               pend_r;
  logic [BIT_W-1:0]   pend_bit_r;
  logic [STAT_W-1:0]  status_r;

  logic [COORD_W-1:0] h_ext, x_plus_h, y_plus_h;
  logic [COORD_W-1:0] scan_x, scan_y;
  logic [PIX_W-1:0]   scan_pix, item_pix;
  logic [WORD_W-1:0]  wr_word;
  logic [HALF_W-1:0]  h_grown;
  logic               hit, in_map, edge_touch;

  // Window extent arithmetic.
  assign h_ext    = {1'b0, h_r};
  assign x_plus_h = x_r + h_ext;
  assign y_plus_h = y_r + h_ext;
  assign h_grown  = h_r + HALF_W'(cfg.step);
  assign edge_touch = (x_r <= h_ext) || (y_r <= h_ext) ||
                      (x_plus_h >= cfg.cols) || (y_plus_h >= cfg.rows);

  // Pixel currently addressed by the ring walk: top, bottom, left, right side.
  always_comb begin
    scan_x = seg_r[1] ? (seg_r[0] ? hi_x_r : lo_x_r) : (lo_x_r + COORD_W'(idx_r));
    scan_y = seg_r[1] ? (lo_y_r + COORD_W'(idx_r)) : (seg_r[0] ? hi_y_r : lo_y_r);
  end
  assign scan_pix = pix_index(scan_x, scan_y);
  assign item_pix = pix_index(x_r, y_r);
  assign hit      = pend_r && map_rdata[pend_bit_r];
  assign in_map   = ({2'b0, item_x} < COORD_W'(MAX_COLS)) &&
                    ({3'b0, item_y} < COORD_W'(MAX_ROWS));

  // Read-modify-write word for a pixel store.
  always_comb begin
    wr_word = map_rdata;
    wr_word[item_pix[BIT_W-1:0]] = pix_nz_r;
  end

  // Map requests issued by the sequencer.
  always_comb begin
    map_req       = '0;
    map_req.wdata = wr_word;
    unique case (state_r)
      S_WRRD: begin
        map_req.rd   = 1'b1;
        map_req.addr = item_pix[PIX_W-1:BIT_W];
      end
      S_WRWB: begin
        map_req.wr   = 1'b1;
        map_req.addr = item_pix[PIX_W-1:BIT_W];
      end
      S_SCAN: begin
        map_req.rd   = 1'b1;
        map_req.addr = scan_pix[PIX_W-1:BIT_W];
      end
      default: begin
        map_req.rd = 1'b0;
      end
    endcase
  end

  assign item_ready      = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_RESP);
  assign res.status      = status_r;
  assign res.window_size = (status_r == STAT_OK) ? {h_r, 1'b0} : '0;

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      h_r      <= '0;
      found_r  <= 1'b0;
      pend_r   <= 1'b0;
      status_r <= STAT_OK;
    end else begin
      pend_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (item_accept) begin
            x_r      <= COORD_W'(item_x);
            y_r      <= COORD_W'(item_y);
            pix_nz_r <= (item_pixel != '0);
            if (item_kind == KIND_WRITE) begin
              state_r <= in_map ? S_WRRD : S_IDLE;
            end else begin
              h_r     <= HALF_W'(cfg.init_half);
              state_r <= S_QCHK;
            end
          end
        end
        S_WRRD: begin
          state_r <= S_WRWB;
        end
        S_WRWB: begin
          state_r <= S_IDLE;
        end
        S_QCHK: begin
          if ((x_r < h_ext) || (y_r < h_ext)) begin
            status_r <= STAT_LOW;
            state_r  <= S_RESP;
          end else if ((x_plus_h > cfg.cols) || (y_plus_h > cfg.rows)) begin
            status_r <= STAT_HIGH;
            state_r  <= S_RESP;
          end else begin
            status_r <= STAT_OK;
            state_r  <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (edge_touch) begin
            state_r <= S_RESP;
          end else if (h_r == '0) begin
            // An empty ring has nothing to find.
            found_r <= 1'b0;
            state_r <= S_GROW;
          end else begin
            lo_x_r  <= x_r - h_ext;
            hi_x_r  <= x_plus_h - 1'b1;
            lo_y_r  <= y_r - h_ext;
            hi_y_r  <= y_plus_h - 1'b1;
            seg_r   <= 2'd0;
            idx_r   <= '0;
            last_r  <= HALF_W'({h_r[HALF_W-2:0], 1'b0} - 1'b1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_r     <= 1'b1;
          pend_bit_r <= scan_pix[BIT_W-1:0];
          if (idx_r == last_r) begin
            idx_r <= '0;
            seg_r <= seg_r + 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
          // A nonzero pixel ends the scan early.
          if (hit) begin
            found_r <= 1'b1;
            state_r <= S_GROW;
          end else if ((idx_r == last_r) && (seg_r == 2'd3)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          found_r <= hit;
          state_r <= S_GROW;
        end
        S_GROW: begin
          h_r <= h_grown;
          if (!found_r || (cfg.step == '0) || (h_grown >= HALF_W'(cfg.max_half))) begin
            state_r <= S_RESP;
          end else begin
            state_r <= S_LOOP;
          end
        end
        S_RESP: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/growing_window_clear_border_search_top.sv */
// Growing-window clear-border search.
// Input channel (in_valid / in_stall): a write request (in_kind 0) stores whether
// in_pixel_value is nonzero at (in_pos_x, in_pos_y); writes outside the map are
// dropped and no write gives a result. A query request (in_kind 1) centers a
// square of half size initial_half_size at (in_pos_x, in_pos_y), grows it by
// grow_step while its border ring holds a nonzero pixel, and returns one result
// with out_status and out_window_size on the output channel (out_valid / out_stall).
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready.
// A write reads the map word and writes it back with the pixel's bit updated.
// A query first checks the starting window against the edges and, on an edge,
// reports at once; otherwise each ring at half size h is scanned as 8h pixel reads,
// one pixel per cycle on the map read port, and a nonzero pixel ends the scan early.
// After reset the map memory is cleared, one word per cycle through all 65536
// words, with in_stall held high; configuration writes are taken meanwhile.
// Results sit in an output register; while out_stall is high the next request is
// still accepted and worked on, and its result waits until the register frees.
module growing_window_clear_border_search_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [gwcb_pkg::X_W-1:0]          in_pos_x,
  input  logic [gwcb_pkg::Y_W-1:0]          in_pos_y,
  input  logic [gwcb_pkg::PIXV_W-1:0]       in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gwcb_pkg::STAT_W-1:0]       out_status,
  output logic [gwcb_pkg::SIZE_W-1:0]       out_window_size,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gwcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gwcb_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import gwcb_pkg::*;

  logic [COLS_W-1:0] image_cols_r;
  logic [ROWS_W-1:0] image_rows_r;
  logic [INIT_W-1:0] init_half_r;
  logic [STEP_W-1:0] grow_step_r;
  logic [MAXH_W-1:0] max_half_r;

  cfg_t              cfg;
  map_req_t          map_req;
  logic [WORD_W-1:0] map_rdata;
  logic              map_busy;
  logic              item_ready, item_accept;
  logic              res_valid, res_take;
  res_t              res;
  logic              out_valid_r;
  res_t              out_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_cols_r <= COLS_W'(2048);
      image_rows_r <= ROWS_W'(1024);
      init_half_r  <= INIT_W'(20);
      grow_step_r  <= STEP_W'(20);
      max_half_r   <= MAXH_W'(250);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: image_cols_r <= cfg_data[COLS_W-1:0];
        REG_IMAGE_ROWS: image_rows_r <= cfg_data[ROWS_W-1:0];
        REG_INIT_HALF:  init_half_r  <= cfg_data[INIT_W-1:0];
        REG_GROW_STEP:  grow_step_r  <= cfg_data[STEP_W-1:0];
        REG_MAX_HALF:   max_half_r   <= cfg_data[MAXH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Image size in use, limited to the map.
  always_comb begin
    cfg.cols      = ({1'b0, image_cols_r} < COORD_W'(MAX_COLS)) ?
                    COORD_W'(image_cols_r) : COORD_W'(MAX_COLS);
    cfg.rows      = ({2'b0, image_rows_r} < COORD_W'(MAX_ROWS)) ?
                    COORD_W'(image_rows_r) : COORD_W'(MAX_ROWS);
    cfg.init_half = init_half_r;
    cfg.step      = grow_step_r;
    cfg.max_half  = max_half_r;
  end

  assign in_stall    = !item_ready || map_busy;
  assign item_accept = in_valid && !in_stall;

  gwcb_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata),
    .busy  (map_busy)
  );

  gwcb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_accept (item_accept),
    .item_kind   (in_kind),
    .item_x      (in_pos_x),
    .item_y      (in_pos_y),
    .item_pixel  (in_pixel_value),
    .item_ready  (item_ready),
    .map_req     (map_req),
    .map_rdata   (map_rdata),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // Output register between the sequencer and the receiver.
  assign res_take = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_window_size = out_r.window_size;

  // No request is taken while the map is still being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("request window open right after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !map_busy)
    else $error("request accepted during map clearing");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == STAT_OK) || (out_r.status == STAT_LOW) ||
                    (out_r.status == STAT_HIGH))
    else $error("result with undefined status");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != STAT_OK) |-> out_r.window_size == '0)
    else $error("edge report carries a window size");

endmodule

/* verif/growing_window_clear_border_search_top_tb.sv */
`timescale 1ns / 1ps

module growing_window_clear_border_search_top_tb;
  import gwcb_pkg::*;

  localparam int HOLD_CYCLES   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SCENES        = 6;
  localparam int SCENE_ITEMS   = 21;
  localparam int CLUSTER_R     = 48;
  localparam int TIME_LIMIT_NS = 60_000_000;
  localparam int SCRIPT_LEN    = 36;

  typedef enum {OP_CFG, OP_WRITE, OP_QUERY} step_op_t;

  // One row of the directed script. For a register write, col holds the
  // index and row the data. A query with known set carries its answer.
  typedef struct {
    step_op_t op;
    int       col;
    int       row;
    int       pix;
    bit       known;
    int       status;
    int       size;
  } step_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_kind;
  logic [X_W-1:0]       in_pos_x;
  logic [Y_W-1:0]       in_pos_y;
  logic [PIXV_W-1:0]    in_pixel_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    out_status;
  logic [SIZE_W-1:0]    out_window_size;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Shadow of the nonzero map and of the registers.
  bit [MAX_COLS-1:0] nz_rows [MAX_ROWS];
  logic [COLS_W-1:0] img_cols   = 12'd2048;
  logic [ROWS_W-1:0] img_rows   = 11'd1024;
  logic [INIT_W-1:0] start_half = 10'd20;
  logic [STEP_W-1:0] step_half  = 10'd20;
  logic [MAXH_W-1:0] stop_half  = 11'd250;

  res_t pending_windows [$];
  int   error_count  = 0;
  bit   steady       = 1'b0;
  bit   hold_pending = 1'b0;
  bit   hold_active  = 1'b0;

  step_row_t script [SCRIPT_LEN] = '{
    // Edge reports and plain sizes under the reset settings.
    '{OP_QUERY,            5,  500,   0, 1'b1, STAT_LOW,     0},
    '{OP_QUERY,          500,    5,   0, 1'b1, STAT_LOW,     0},
    '{OP_QUERY,         2047,  500,   0, 1'b1, STAT_HIGH,    0},
    '{OP_QUERY,          500, 1023,   0, 1'b1, STAT_HIGH,    0},
    '{OP_QUERY,         1000,  500,   0, 1'b1, STAT_OK,     80},
    '{OP_QUERY,           20,  500,   0, 1'b1, STAT_OK,     40},
    '{OP_QUERY,         2028, 1003,   0, 1'b1, STAT_OK,     40},
    // A mark on the first ring makes the window grow once more.
    '{OP_WRITE,          980,  500, 255, 1'b0, STAT_OK,      0},
    '{OP_QUERY,         1000,  500,   0, 1'b0, STAT_OK,      0},
    '{OP_WRITE,            0,    0,   1, 1'b0, STAT_OK,      0},
    '{OP_WRITE,         2047, 1023, 128, 1'b0, STAT_OK,      0},
    '{OP_WRITE,          980,  500,   0, 1'b0, STAT_OK,      0},
    '{OP_QUERY,         1000,  500,   0, 1'b0, STAT_OK,      0},
    // Image size beyond the map, zero half size, largest step.
    '{OP_CFG,   REG_IMAGE_COLS, 4095, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_IMAGE_ROWS, 2047, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_INIT_HALF,     0, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_GROW_STEP,  1023, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_MAX_HALF,   2047, 0, 1'b0, STAT_OK,      0},
    '{OP_QUERY,         2047, 1023,   0, 1'b1, STAT_OK,   2046},
    '{OP_QUERY,            0,    0,   0, 1'b1, STAT_OK,      0},
    '{OP_CFG,   REG_INIT_HALF,  1023, 0, 1'b0, STAT_OK,      0},
    '{OP_QUERY,         1023,  511,   0, 1'b1, STAT_LOW,     0},
    '{OP_QUERY,         1023, 1023,   0, 1'b1, STAT_HIGH,    0},
    // Zero step with a marked ring answers the first size at once.
    '{OP_CFG,   REG_INIT_HALF,    10, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_GROW_STEP,     0, 0, 1'b0, STAT_OK,      0},
    '{OP_WRITE,          510,  300,  77, 1'b0, STAT_OK,      0},
    '{OP_QUERY,          520,  300,   0, 1'b0, STAT_OK,      0},
    // Growth stops at the smallest maximum after a single ring.
    '{OP_CFG,   REG_GROW_STEP,  1023, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_INIT_HALF,     1, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_MAX_HALF,      1, 0, 1'b0, STAT_OK,      0},
    '{OP_WRITE,          519,  299, 200, 1'b0, STAT_OK,      0},
    '{OP_QUERY,          520,  300,   0, 1'b0, STAT_OK,      0},
    // Smallest image.
    '{OP_CFG,   REG_IMAGE_COLS,    1, 0, 1'b0, STAT_OK,      0},
    '{OP_CFG,   REG_IMAGE_ROWS,    1, 0, 1'b0, STAT_OK,      0},
    '{OP_QUERY,            1,    1,   0, 1'b1, STAT_HIGH,    0},
    '{OP_QUERY,            0,    0,   0, 1'b1, STAT_LOW,     0}
  };

  growing_window_clear_border_search_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_window_size (out_window_size),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic void flag_error(string what);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", what);
  endfunction

  function automatic bit pixel_at(int x, int y);
    if (x < 0 || y < 0 || x >= MAX_COLS || y >= MAX_ROWS) return 1'b0;
    return nz_rows[y][x];
  endfunction

  // Border ring of the square: columns x-h..x+h-1, rows y-h..y+h-1.
  function automatic bit ring_has_mark(int x, int y, int h);
    bit seen;
    seen = 1'b0;
    if (h == 0) return 1'b0;
    for (int i = x - h; i < x + h; i++)
      seen |= pixel_at(i, y - h) | pixel_at(i, y + h - 1);
    for (int i = y - h; i < y + h; i++)
      seen |= pixel_at(x - h, i) | pixel_at(x + h - 1, i);
    return seen;
  endfunction

  // Window that a query centered at (x, y) settles on.
  function automatic res_t clear_window_of(int x, int y);
    res_t r;
    int   cols, rows, h;
    bit   marked, done;
    cols = (img_cols < MAX_COLS) ? int'(img_cols) : MAX_COLS;
    rows = (img_rows < MAX_ROWS) ? int'(img_rows) : MAX_ROWS;
    h = start_half;
    r.window_size = '0;
    if (x < h || y < h) begin
      r.status = STAT_LOW;
      return r;
    end
    if (x + h > cols || y + h > rows) begin
      r.status = STAT_HIGH;
      return r;
    end
    done = 1'b0;
    while (!done) begin
      if (x <= h || y <= h || x + h >= cols || y + h >= rows) begin
        done = 1'b1;
      end else begin
        marked = ring_has_mark(x, y, h);
        if (marked && step_half == 0) begin
          done = 1'b1;
        end else begin
          h += step_half;
          done = !marked || h >= stop_half;
        end
      end
    end
    r.status = STAT_OK;
    r.window_size = SIZE_W'(2 * h);
    return r;
  endfunction

  // Drop the request line, wait for every outstanding result, then let a
  // write in flight finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; starts and ends at a falling edge.
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_COLS: img_cols   = data[COLS_W-1:0];
      REG_IMAGE_ROWS: img_rows   = data[ROWS_W-1:0];
      REG_INIT_HALF:  start_half = data[INIT_W-1:0];
      REG_GROW_STEP:  step_half  = data[STEP_W-1:0];
      REG_MAX_HALF:   stop_half  = data[MAXH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One request on the input channel; starts and ends at a falling edge.
  // A query pushes either the given answer or the predicted window.
  task automatic send_request(logic kind, int x, int y, int pix, bit known, res_t answer);
    int gap, xm, ym;
    gap = idle_len();
    xm = x & ((1 << X_W) - 1);
    ym = y & ((1 << Y_W) - 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_pos_x       <= X_W'(xm);
    in_pos_y       <= Y_W'(ym);
    in_pixel_value <= PIXV_W'(pix);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_WRITE) nz_rows[ym][xm] = (pix[PIXV_W-1:0] != 0);
    else pending_windows.push_back(known ? answer : clear_window_of(xm, ym));
    @(negedge clk);
  endtask

  // A random image setting, a cluster of marks around one center, and
  // queries mostly near that center with some scattered noise.
  task automatic run_scene(bit with_hold);
    int   sel, cols, rows, ecols, erows, cx, cy, x, y, pix, r;
    res_t none;
    none = '0;
    wait_idle();
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      cols = $urandom_range(0, 3);
      rows = $urandom_range(0, 3);
    end else if (sel == 1) begin
      cols = $urandom_range(2049, 4095);
      rows = $urandom_range(40, 128);
    end else begin
      cols = $urandom_range(40, 300);
      rows = $urandom_range(40, 128);
    end
    set_register(REG_IMAGE_COLS, CFG_DAT_W'(cols));
    set_register(REG_IMAGE_ROWS, CFG_DAT_W'(rows));
    set_register(REG_INIT_HALF, CFG_DAT_W'($urandom_range(0, 12)));
    set_register(REG_GROW_STEP, CFG_DAT_W'($urandom_range(0, 8)));
    set_register(REG_MAX_HALF, CFG_DAT_W'($urandom_range(1, 80)));
    ecols = (cols < MAX_COLS) ? cols : MAX_COLS;
    erows = (rows < MAX_ROWS) ? rows : MAX_ROWS;
    cx = $urandom_range(ecols / 4, (3 * ecols) / 4);
    cy = $urandom_range(erows / 4, (3 * erows) / 4);

    // Hold the result side off so the block backs up into its input.
    if (with_hold) begin
      hold_pending = 1'b1;
      while (!hold_active) @(negedge clk);
    end

    repeat (SCENE_ITEMS) begin
      r = $urandom_range(0, 99);
      pix = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
      if (r < 50) begin
        x = cx + int'($urandom_range(0, 2 * CLUSTER_R)) - CLUSTER_R;
        y = cy + int'($urandom_range(0, 2 * CLUSTER_R)) - CLUSTER_R;
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        send_request(KIND_WRITE, x, y, pix, 1'b0, none);
      end else if (r < 60) begin
        send_request(KIND_WRITE, $urandom_range(0, 2047), $urandom_range(0, 1023),
                     $urandom_range(0, 255), 1'b0, none);
      end else if (r < 90) begin
        x = cx + int'($urandom_range(0, 6)) - 3;
        y = cy + int'($urandom_range(0, 6)) - 3;
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        send_request(KIND_QUERY, x, y, pix, 1'b0, none);
      end else begin
        send_request(KIND_QUERY, $urandom_range(0, 2047), $urandom_range(0, 1023),
                     pix, 1'b0, none);
      end
    end
  endtask

  // Result side stall: random gaps, plus one long hold on request.
  initial begin : drive_out_stall
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_active  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
      end else begin
        n = idle_len();
        out_stall <= (n != 0);
        repeat ((n == 0) ? 1 : n) @(negedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expected window.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        flag_error($sformatf("result with none expected: status %0d size %0d",
                             out_status, out_window_size));
      end else begin
        want = pending_windows.pop_front();
        if (out_status !== want.status)
          flag_error($sformatf("status: expected %0d, got %0d", want.status, out_status));
        if (out_window_size !== want.window_size)
          flag_error($sformatf("window size: expected %0d, got %0d",
                               want.window_size, out_window_size));
      end
    end
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("growing_window_clear_border_search_top_tb failed");
    $finish;
  end

  // Main sequence: reset, directed script, random scenes, drain.
  initial begin : main_sequence
    res_t answer;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_pixel_value = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_IMAGE_COLS;
    cfg_data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      answer.status      = STAT_W'(script[i].status);
      answer.window_size = SIZE_W'(script[i].size);
      if (script[i].op == OP_CFG) begin
        wait_idle();
        set_register(CFG_IDX_W'(script[i].col), CFG_DAT_W'(script[i].row));
      end else begin
        send_request((script[i].op == OP_QUERY) ? KIND_QUERY : KIND_WRITE,
                     script[i].col, script[i].row, script[i].pix,
                     script[i].known, answer);
      end
    end

    for (int s = 0; s < SCENES; s++) begin
      steady = (s == 2);
      run_scene(s == 0);
    end
    steady = 1'b0;

    wait_idle();
    if (error_count == 0 && pending_windows.size() == 0) begin
      $display("growing_window_clear_border_search_top_tb passed");
    end else begin
      $display("growing_window_clear_border_search_top_tb failed");
    end
    $finish;
  end

endmodule
